// ----- design/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared widths, register indexes and stage types of the 3x3 local binary
// pattern block.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIXEL_W            = 8;
   localparam int COORD_W            = 11;
   localparam int CSR_DATA_W         = 12;
   localparam int CSR_INDEX_W        = 1;
   localparam int NEIGHBORS          = 8;
   localparam int MIN_SIZE           = 3;
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;

   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // one accepted pixel with its position decisions
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               emit;
      logic               last;
   } lbp_item_type;

   // upper and middle line pixels at the current column
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
   } lbp_lines_type;

   // write-back request from the window stage to the line memory
   typedef struct packed {
      logic               write_en;
      logic [PIXEL_W-1:0] pixel;
   } lbp_wb_type;

endpackage

// ----- design/lbp_req_if.sv -----
// ----------------------------------------------------------------------------
// lbp_req_if
// Pixel request channel: valid/ready handshake with grey level and frame mark.
// ----------------------------------------------------------------------------
interface lbp_req_if;
   import lbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   logic               frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);

endinterface

// ----- design/lbp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lbp_rsp_if
// Pattern result channel: valid/ready handshake with code and position.
// ----------------------------------------------------------------------------
interface lbp_rsp_if;
   import lbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pattern_code;
   logic [COORD_W-1:0] column;
   logic [COORD_W-1:0] row;
   logic               frame_last;

   modport source (output valid, output pattern_code, output column, output row,
                   output frame_last, input ready);
   modport sink   (input valid, input pattern_code, input column, input row,
                   input frame_last, output ready);

endinterface

// ----- design/lbp_position.sv -----
// ----------------------------------------------------------------------------
// lbp_position
// Size registers, raster position counters and the per-pixel border, end of
// frame and line memory address decisions.
// ----------------------------------------------------------------------------
module lbp_position #(
   parameter int MAX_WIDTH  = lbp_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 accept,
   input  logic [lbp_pkg::PIXEL_W-1:0]          pixel_value,
   input  logic                                 frame_start,
   output lbp_pkg::lbp_item_type                item,
   output logic [$clog2(MAX_WIDTH)-1:0]         line_addr
);
   import lbp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = RW + 1;

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;

   logic [WW-1:0] width;
   logic [HW-1:0] height;
   logic [CW-1:0] col;
   logic [RW-1:0] row;
   logic [WW-1:0] col_ext, col_nxt;
   logic [HW-1:0] row_ext, row_nxt;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate the programmed size into the supported range
   always_comb begin
      if (width_ff < CSR_DATA_W'(MIN_SIZE)) begin
         width = WW'(MIN_SIZE);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         width = WW'(MAX_WIDTH);
      end else begin
         width = WW'(width_ff);
      end
      if (height_ff < CSR_DATA_W'(MIN_SIZE)) begin
         height = HW'(MIN_SIZE);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         height = HW'(MAX_HEIGHT);
      end else begin
         height = HW'(height_ff);
      end
   end

   always_comb begin
      col     = frame_start ? '0 : col_ff;
      row     = frame_start ? '0 : row_ff;
      col_ext = {1'b0, col};
      row_ext = {1'b0, row};
      col_nxt = col_ext + WW'(1);
      row_nxt = row_ext + HW'(1);

      item.pixel  = pixel_value;
      item.column = COORD_W'(col - CW'(1));
      item.row    = COORD_W'(row - RW'(1));
      item.emit   = (row >= RW'(2)) && (col >= CW'(2)) && (row_ext < height) &&
                    (col_ext < width);
      item.last   = (row_ext == height - HW'(1)) && (col_ext == width - WW'(1));

      if (32'(col) < MAX_WIDTH) begin
         line_addr = col;
      end else begin
         line_addr = CW'(MAX_WIDTH - 1);
      end

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_nxt >= width) begin
            col_in = '0;
            row_in = (row_nxt >= height) ? '0 : row_nxt[RW-1:0];
         end else begin
            col_in = col_nxt[CW-1:0];
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- design/lbp_line_mem.sv -----
// ----------------------------------------------------------------------------
// lbp_line_mem
// Line memory holding the two previous rows, one entry per column with the
// upper and middle pixel side by side. Read on accept, written back when the
// pixel leaves the window stage, with forwarding for a same-entry overlap.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
   parameter int MAX_WIDTH = lbp_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  lbp_pkg::lbp_wb_type          wb,
   output lbp_pkg::lbp_lines_type       lines
);
   import lbp_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];

   logic [2*PIXEL_W-1:0] rdata_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic                 fwd_ff, fwd_in;
   logic [2*PIXEL_W-1:0] fwd_data_ff;
   logic [2*PIXEL_W-1:0] wr_data;

   // the entry moves down one row: old middle becomes upper
   assign wr_data = {lines.mid, wb.pixel};
   assign lines   = fwd_ff ? fwd_data_ff : rdata_ff;

   always_comb begin
      fwd_in = fwd_ff;
      if (rd_en) begin
         fwd_in = wb.write_en && (wr_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff   <= mem[rd_addr];
         wr_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (wb.write_en) begin
         mem[wr_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

// ----- design/lbp_window.sv -----
// ----------------------------------------------------------------------------
// lbp_window
// Window stage: holds the pixel whose line data is being read, keeps the two
// previous columns, forms the eight neighbor comparisons and drives the
// result register.
// ----------------------------------------------------------------------------
module lbp_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lbp_pkg::lbp_item_type  item,
   input  lbp_pkg::lbp_lines_type lines,
   output logic                   can_accept,
   output lbp_pkg::lbp_wb_type    wb,
   lbp_rsp_if.source              rsp
);
   import lbp_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   lbp_item_type         s1_item_ff;
   logic [PIXEL_W-1:0]   win_ff [6];
   logic                 out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]   out_code_ff;
   logic [COORD_W-1:0]   out_column_ff;
   logic [COORD_W-1:0]   out_row_ff;
   logic                 out_last_ff;

   logic                 s1_adv;
   logic [PIXEL_W-1:0]   nb [NEIGHBORS];
   logic [PIXEL_W-1:0]   centre;
   logic [PIXEL_W-1:0]   code;

   // a pixel without a result never waits for the output side
   assign s1_adv     = s1_valid_ff &&
                       (!s1_item_ff.emit || !out_valid_ff || rsp.ready);
   assign can_accept = !s1_valid_ff || s1_adv;

   assign wb.write_en = s1_adv;
   assign wb.pixel    = s1_item_ff.pixel;

   always_comb begin
      centre = win_ff[4];
      nb[0]  = win_ff[0];
      nb[1]  = win_ff[3];
      nb[2]  = lines.top;
      nb[3]  = lines.mid;
      nb[4]  = s1_item_ff.pixel;
      nb[5]  = win_ff[5];
      nb[6]  = win_ff[2];
      nb[7]  = win_ff[1];
      for (int k = 0; k < NEIGHBORS; k++) begin
         code[k] = nb[k] > centre;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_item_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= lines.top;
         win_ff[4] <= lines.mid;
         win_ff[5] <= s1_item_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
      end
      if (s1_adv && s1_item_ff.emit) begin
         out_code_ff   <= code;
         out_column_ff <= s1_item_ff.column;
         out_row_ff    <= s1_item_ff.row;
         out_last_ff   <= s1_item_ff.last;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pattern_code = out_code_ff;
   assign rsp.column       = out_column_ff;
   assign rsp.row          = out_row_ff;
   assign rsp.frame_last   = out_last_ff;

endmodule

// ----- design/local_binary_pattern_3x3.sv -----
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3
// Streaming 3x3 local binary pattern over a raster of grey pixels.
//
//   channel  dir  handshake        carries
//   req      in   valid / ready    pixel_value, frame_start
//   rsp      out  valid / ready    pattern_code, column, row, frame_last
//   csr      in   write enable     csr_index, csr_wdata (image width, height)
//
// One pixel per cycle sustained while rsp is not stalled; a pixel is registered in
// the window stage alongside its line memory read, then its result in the output
// register. Synchronous reset clears counters, window and valids; the line
// memory needs no clearing pass. A stalled rsp holds its result; req.ready
// drops only while the pixel in the window stage has a result and rsp holds
// a result that is not taken in that cycle.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3 #(
   parameter int MAX_WIDTH  = lbp_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   lbp_req_if.sink                         req,
   lbp_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lbp_pkg::*;

   logic                         accept;
   logic                         can_accept;
   lbp_item_type                 item;
   logic [$clog2(MAX_WIDTH)-1:0] line_addr;
   lbp_lines_type                lines;
   lbp_wb_type                   wb;

   assign req.ready = can_accept;
   assign accept    = req.valid && can_accept;

   lbp_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .pixel_value  (req.pixel_value),
      .frame_start  (req.frame_start),
      .item         (item),
      .line_addr    (line_addr)
   );

   lbp_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (line_addr),
      .wb      (wb),
      .lines   (lines)
   );

   lbp_window u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (item),
      .lines      (lines),
      .can_accept (can_accept),
      .wb         (wb),
      .rsp        (rsp)
   );

endmodule
